// ===== rtl/core/assert_macros.svh =====
// shared assertion macros for the tessellator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define BSFT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define BSFT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bsft_pkg.sv =====
package bsft_pkg;

    // default sizing
    localparam int ARC_STEPS_DEF       = 36;
    localparam int COORD_FRAC_BITS_DEF = 14;

    // datapath widths
    localparam int DVD_W  = 51;
    localparam int DVS_W  = 15;
    localparam int RAD_W  = 45;
    localparam int CORD_W = 48;
    localparam int SQUARE_LEN = 6;

    // shape codes
    localparam logic [1:0] MODE_SQUARE = 2'd0;
    localparam logic [1:0] MODE_ROUND  = 2'd1;
    localparam logic [1:0] MODE_CIRCLE = 2'd2;

    // register indexes
    typedef enum logic [1:0] {
        CFG_SHAPE_MODE    = 2'd0,
        CFG_CORNER_RADIUS = 2'd1,
        CFG_CANVAS_WIDTH  = 2'd2,
        CFG_CANVAS_HEIGHT = 2'd3
    } cfg_index_t;

    // first quarter of the 10-degree sine table, 1.0 is 65536
    localparam logic [16:0] QUARTER_SIN [10] = '{
        17'd0, 17'd11380, 17'd22415, 17'd32768, 17'd42126,
        17'd50203, 17'd56756, 17'd61584, 17'd64540, 17'd65536
    };

    typedef struct packed {
        logic [15:0] min_x;
        logic [15:0] min_y;
        logic [15:0] max_x;
        logic [15:0] max_y;
        logic [15:0] scale;
        logic        restart;
    } box_t;

    typedef struct packed {
        logic signed [15:0] vertex_x;
        logic signed [15:0] vertex_y;
        logic [5:0]         vertex_index;
        logic [31:0]        fan_start;
        logic [5:0]         fan_length;
        logic               last;
    } vtx_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic [22:0]        a;
        logic signed [17:0] b;
    } mul_req_t;

    // sine of k*10 degrees, k in 0..44
    function automatic logic signed [17:0] sin_tab(input logic [5:0] k);
        logic [5:0]         m;
        logic [5:0]         idx;
        logic               neg;
        logic signed [17:0] mag;
        m = (k >= 6'd36) ? k - 6'd36 : k;
        if (m <= 6'd9)
        begin
            idx = m;
            neg = 1'b0;
        end
        else if (m <= 6'd18)
        begin
            idx = 6'd18 - m;
            neg = 1'b0;
        end
        else if (m <= 6'd27)
        begin
            idx = m - 6'd18;
            neg = 1'b1;
        end
        else
        begin
            idx = 6'd36 - m;
            neg = 1'b1;
        end
        mag = $signed({1'b0, QUARTER_SIN[idx[3:0]]});
        return neg ? -mag : mag;
    endfunction

endpackage

// ===== rtl/core/bsft_box_if.sv =====
interface bsft_box_if;
    logic            valid;
    logic            ready;
    bsft_pkg::box_t  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/bsft_vtx_if.sv =====
interface bsft_vtx_if;
    logic            valid;
    logic            ready;
    bsft_pkg::vtx_t  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/background_shape_fan_tessellator.sv =====
// Background fan tessellator: takes one box per request and returns its background as
// projection-space vertices, one vertex per request on the output channel. Square mode
// returns 6 vertices. Rounded and circle modes return ARC_STEPS+2 vertices: the two radii
// come from a bit-serial divider, and every arc vertex takes four passes through the
// shared 23x18 multiplier before it goes to the output. The input is not ready until
// the last vertex of the current box has been taken.
`include "assert_macros.svh"

module background_shape_fan_tessellator #(
    parameter int ARC_STEPS       = bsft_pkg::ARC_STEPS_DEF,
    parameter int COORD_FRAC_BITS = bsft_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    bsft_box_if.sink    box,
    bsft_vtx_if.source  vertex
);

    localparam int CW = bsft_pkg::CORD_W;
    localparam logic [5:0] ARC_LEN = 6'(ARC_STEPS + 2);
    localparam logic [5:0] SQ_LEN  = 6'(bsft_pkg::SQUARE_LEN);
    localparam logic [6:0] ARC_W   = 7'(ARC_STEPS);
    localparam logic signed [CW-1:0] ONE32 = CW'(64'sd1 <<< 32);
    localparam logic signed [CW-1:0] ROUND = CW'(64'sd1 <<< (31 - COORD_FRAC_BITS));
    localparam int SHIFT = 32 - COORD_FRAC_BITS;
    localparam logic [bsft_pkg::DVD_W-1:0] RAD_CAP = bsft_pkg::DVD_W'(64'd1 << 44);

    typedef enum logic [14:0] {
        S_IDLE = 15'b000000000000001,
        S_RS   = 15'b000000000000010,
        S_RSW  = 15'b000000000000100,
        S_FW   = 15'b000000000001000,
        S_FH   = 15'b000000000010000,
        S_FM   = 15'b000000000100000,
        S_DX   = 15'b000000001000000,
        S_DY   = 15'b000000010000000,
        S_VTX  = 15'b000000100000000,
        S_M1   = 15'b000001000000000,
        S_M2   = 15'b000010000000000,
        S_M3   = 15'b000100000000000,
        S_M4   = 15'b001000000000000,
        S_OUT  = 15'b010000000000000,
        S_SPR  = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]  shape_cfg_reg;
    logic [15:0] radius_reg;
    logic [13:0] width_reg;
    logic [13:0] height_reg;
    logic [31:0] total_reg;

    bsft_pkg::box_t box_reg;
    logic [1:0]  mode_reg;
    logic        fit_reg;
    logic [31:0] start_reg;
    logic [5:0]  len_reg;
    logic [5:0]  vi_reg;
    logic [5:0]  k_reg;
    logic [5:0]  kr_reg;
    logic [31:0] rs_reg;
    logic [29:0] mw_reg;
    logic [29:0] m_reg;
    logic [bsft_pkg::RAD_W-1:0] rx_reg;
    logic [bsft_pkg::RAD_W-1:0] ry_reg;
    logic signed [63:0] acc_reg;
    logic signed [CW-1:0] x_reg;
    logic signed [15:0] ox_reg;
    logic signed [15:0] oy_reg;

    bsft_pkg::div_req_t div_req;
    bsft_pkg::div_rsp_t div_rsp;
    bsft_pkg::mul_req_t mul_req;
    logic signed [41:0] prod;

    logic [13:0] wd, hd;
    logic        arc_mode;
    logic [16:0] sum_x, sum_y;
    logic [15:0] adx, ady;
    logic signed [CW-1:0] cx, cy, dxo, dyo, xc0, xc1, yc0, yc1;
    logic signed [CW-1:0] sx0, sx1, sy0, sy1, bx, by, rx_s, ry_s;
    logic signed [CW-1:0] ox_src, oy_src;
    logic signed [63:0]   trig_sum;
    logic signed [CW-1:0] trig_off;
    logic signed [17:0]   cosv, sinv;
    logic [1:0]  quad;
    logic        last_vtx;
    logic        load_out;
    logic [29:0] m_max;
    logic [bsft_pkg::RAD_W-1:0] quo_cap;
    logic [6:0]  k_t;
    logic [5:0]  k_step;
    logic [5:0]  kr_step;

    // rounded output with saturation
    function automatic logic signed [15:0] to_out(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] t;
        logic signed [CW-1:0] q;
        t = v + ROUND;
        q = t >>> SHIFT;
        if (q > $signed(CW'(32767)))
            return 16'sh7fff;
        else if (q < -$signed(CW'(32768)))
            return 16'sh8000;
        else
            return q[15:0];
    endfunction

    // radius dividend from radius times scale
    function automatic logic [bsft_pkg::DVD_W-1:0] rs_dvd(input logic [31:0] rs,
                                                          input logic circ);
        return circ ? {rs, 19'b0} : {1'b0, rs, 18'b0};
    endfunction

    bsft_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    bsft_mul u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    // box geometry
    always_comb
    begin
        wd       = (width_reg == 14'd0) ? 14'd1 : width_reg;
        hd       = (height_reg == 14'd0) ? 14'd1 : height_reg;
        arc_mode = (mode_reg == bsft_pkg::MODE_ROUND) || (mode_reg == bsft_pkg::MODE_CIRCLE);
        sum_x = {1'b0, box_reg.min_x} + {1'b0, box_reg.max_x};
        sum_y = {1'b0, box_reg.min_y} + {1'b0, box_reg.max_y};
        adx = (box_reg.max_x > box_reg.min_x) ? box_reg.max_x - box_reg.min_x
                                              : box_reg.min_x - box_reg.max_x;
        ady = (box_reg.max_y > box_reg.min_y) ? box_reg.max_y - box_reg.min_y
                                              : box_reg.min_y - box_reg.max_y;
        cx = $signed({15'b0, sum_x, 16'b0}) - ONE32;
        cy = ONE32 - $signed({15'b0, sum_y, 16'b0});
        rx_s = $signed({3'b0, rx_reg});
        ry_s = $signed({3'b0, ry_reg});
        dxo = (mode_reg == bsft_pkg::MODE_CIRCLE) ? '0 : $signed({16'b0, adx, 16'b0}) - rx_s;
        dyo = (mode_reg == bsft_pkg::MODE_CIRCLE) ? '0 : $signed({16'b0, ady, 16'b0}) - ry_s;
        xc0 = cx + dxo;
        xc1 = cx - dxo;
        yc0 = cy + dyo;
        yc1 = cy - dyo;
        sx0 = $signed({15'b0, box_reg.min_x, 17'b0}) - ONE32;
        sx1 = $signed({15'b0, box_reg.max_x, 17'b0}) - ONE32;
        sy0 = ONE32 - $signed({15'b0, box_reg.min_y, 17'b0});
        sy1 = ONE32 - $signed({15'b0, box_reg.max_y, 17'b0});
    end

    // arc angle and quarter
    always_comb
    begin
        quad = (k_reg >= 6'd27) ? 2'd3 : (k_reg >= 6'd18) ? 2'd2 : (k_reg >= 6'd9) ? 2'd1 : 2'd0;
        cosv = bsft_pkg::sin_tab(k_reg + 6'd9);
        sinv = bsft_pkg::sin_tab(k_reg);
        bx = (quad == 2'd1 || quad == 2'd2) ? xc1 : xc0;
        by = (quad >= 2'd2) ? yc1 : yc0;
        trig_sum = acc_reg + (64'(prod) <<< 23);
        trig_off = trig_sum[63:16];
        last_vtx = vi_reg == len_reg - 6'd1;
    end

    // next table step: k advances by 36/ARC_STEPS
    always_comb
    begin
        k_t    = {1'b0, kr_reg} + 7'd36;
        k_step = k_reg;
        for (int j = 0; j < 5; j++)
        begin
            if (k_t >= ARC_W)
            begin
                k_t    = k_t - ARC_W;
                k_step = k_step + 6'd1;
            end
        end
        kr_step = k_t[5:0];
    end

    // radius cap and fit maximum
    always_comb
    begin
        quo_cap = (div_rsp.quotient > RAD_CAP) ? RAD_CAP[bsft_pkg::RAD_W-1:0]
                                               : div_rsp.quotient[bsft_pkg::RAD_W-1:0];
        m_max = (mw_reg > prod[29:0]) ? mw_reg : prod[29:0];
    end

    // sequencer, multiplier and divider operands, vertex source
    always_comb
    begin
        state_next       = state_reg;
        mul_req.a        = '0;
        mul_req.b        = '0;
        div_req.start    = 1'b0;
        div_req.dividend = rs_dvd(prod[31:0], mode_reg == bsft_pkg::MODE_CIRCLE);
        div_req.divisor  = {1'b0, wd};
        ox_src   = cx;
        oy_src   = cy;
        load_out = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (box.valid)
                    state_next = (shape_cfg_reg == bsft_pkg::MODE_ROUND
                                  || shape_cfg_reg == bsft_pkg::MODE_CIRCLE) ? S_RS : S_VTX;
            end
            S_RS:
            begin
                mul_req.a  = {7'b0, radius_reg};
                mul_req.b  = $signed({2'b0, box_reg.scale});
                state_next = S_RSW;
            end
            S_RSW:
            begin
                if (fit_reg)
                    state_next = S_FW;
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = S_DX;
                end
            end
            S_FW:
            begin
                mul_req.a  = {7'b0, adx};
                mul_req.b  = $signed({4'b0, wd});
                state_next = S_FH;
            end
            S_FH:
            begin
                mul_req.a  = {7'b0, ady};
                mul_req.b  = $signed({4'b0, hd});
                state_next = S_FM;
            end
            S_FM:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {4'b0, m_max, 17'b0};
                div_req.divisor  = {wd, 1'b0};
                state_next       = S_DX;
            end
            S_DX:
            begin
                div_req.dividend = fit_reg ? {4'b0, m_reg, 17'b0}
                                           : rs_dvd(rs_reg, mode_reg == bsft_pkg::MODE_CIRCLE);
                div_req.divisor  = fit_reg ? {hd, 1'b0} : {1'b0, hd};
                if (div_rsp.done)
                begin
                    div_req.start = 1'b1;
                    state_next    = S_DY;
                end
            end
            S_DY:
            begin
                if (div_rsp.done)
                    state_next = S_VTX;
            end
            S_VTX:
            begin
                mul_req.a = rx_reg[22:0];
                mul_req.b = cosv;
                if (!arc_mode)
                begin
                    ox_src = (vi_reg == 6'd1 || vi_reg == 6'd3 || vi_reg == 6'd4) ? sx1 : sx0;
                    oy_src = (vi_reg == 6'd2 || vi_reg == 6'd4 || vi_reg == 6'd5) ? sy1 : sy0;
                    load_out   = 1'b1;
                    state_next = S_OUT;
                end
                else if (vi_reg == 6'd0)
                begin
                    load_out   = 1'b1;
                    state_next = S_OUT;
                end
                else if (last_vtx)
                begin
                    if (mode_reg == bsft_pkg::MODE_ROUND)
                    begin
                        ox_src = x_reg;
                        oy_src = yc0;
                    end
                    else
                        ox_src = cx + rx_s;
                    load_out   = 1'b1;
                    state_next = S_OUT;
                end
                else
                    state_next = S_M1;
            end
            S_M1:
            begin
                mul_req.a  = {1'b0, rx_reg[44:23]};
                mul_req.b  = cosv;
                state_next = S_M2;
            end
            S_M2:
            begin
                mul_req.a  = ry_reg[22:0];
                mul_req.b  = sinv;
                state_next = S_M3;
            end
            S_M3:
            begin
                mul_req.a  = {1'b0, ry_reg[44:23]};
                mul_req.b  = sinv;
                state_next = S_M4;
            end
            S_M4:
            begin
                ox_src     = x_reg;
                oy_src     = by + trig_off;
                load_out   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (vertex.ready)
                    state_next = last_vtx ? S_IDLE : S_VTX;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            shape_cfg_reg <= bsft_pkg::MODE_SQUARE;
            radius_reg    <= 16'd0;
            width_reg     <= 14'd1024;
            height_reg    <= 14'd1024;
            total_reg     <= 32'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (bsft_pkg::cfg_index_t'(cfg_index))
                    bsft_pkg::CFG_SHAPE_MODE:    shape_cfg_reg <= cfg_data[1:0];
                    bsft_pkg::CFG_CORNER_RADIUS: radius_reg    <= cfg_data;
                    bsft_pkg::CFG_CANVAS_WIDTH:  width_reg     <= cfg_data[13:0];
                    bsft_pkg::CFG_CANVAS_HEIGHT: height_reg    <= cfg_data[13:0];
                    default:                     radius_reg    <= radius_reg;
                endcase
            end
            if (state_reg == S_IDLE && box.valid)
            begin
                total_reg <= (box.data.restart ? 32'd0 : total_reg)
                             + ((shape_cfg_reg == bsft_pkg::MODE_ROUND
                                 || shape_cfg_reg == bsft_pkg::MODE_CIRCLE)
                                ? 32'(ARC_LEN) : 32'(SQ_LEN));
            end
        end
    end

    // per-box working registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && box.valid)
        begin
            box_reg   <= box.data;
            mode_reg  <= (shape_cfg_reg == bsft_pkg::MODE_ROUND
                          || shape_cfg_reg == bsft_pkg::MODE_CIRCLE)
                         ? shape_cfg_reg : bsft_pkg::MODE_SQUARE;
            fit_reg   <= (shape_cfg_reg == bsft_pkg::MODE_CIRCLE) && (radius_reg == 16'd0);
            start_reg <= box.data.restart ? 32'd0 : total_reg;
            len_reg   <= (shape_cfg_reg == bsft_pkg::MODE_ROUND
                          || shape_cfg_reg == bsft_pkg::MODE_CIRCLE) ? ARC_LEN : SQ_LEN;
            vi_reg    <= 6'd0;
            k_reg     <= 6'd0;
            kr_reg    <= 6'd0;
        end
        if (state_reg == S_RSW)
            rs_reg <= prod[31:0];
        if (state_reg == S_FH)
            mw_reg <= prod[29:0];
        if (state_reg == S_FM)
            m_reg <= m_max;
        if (state_reg == S_DX && div_rsp.done)
            rx_reg <= quo_cap;
        if (state_reg == S_DY && div_rsp.done)
            ry_reg <= quo_cap;
        if (state_reg == S_M1 || state_reg == S_M3)
            acc_reg <= 64'(prod);
        if (state_reg == S_M2)
            x_reg <= bx + trig_off;
        if (load_out)
        begin
            ox_reg <= to_out(ox_src);
            oy_reg <= to_out(oy_src);
        end
        if (state_reg == S_OUT && vertex.ready && !last_vtx)
        begin
            vi_reg <= vi_reg + 6'd1;
            if (arc_mode && vi_reg != 6'd0)
            begin
                k_reg  <= k_step;
                kr_reg <= kr_step;
            end
        end
    end

    // handshake and result payload
    assign box.ready                = state_reg == S_IDLE;
    assign vertex.valid             = state_reg == S_OUT;
    assign vertex.data.vertex_x     = ox_reg;
    assign vertex.data.vertex_y     = oy_reg;
    assign vertex.data.vertex_index = vi_reg;
    assign vertex.data.fan_start    = start_reg;
    assign vertex.data.fan_length   = len_reg;
    assign vertex.data.last         = last_vtx;

    // checks
    `BSFT_ASSERT_IMPL(a_no_overlap, box.ready, !vertex.valid, "input taken during a fan")
    `BSFT_ASSERT_NEXT(a_idle_after_last, vertex.valid && vertex.ready && vertex.data.last,
        box.ready, "block not idle after last vertex")
    `BSFT_ASSERT_IMPL(a_index_range, vertex.valid,
        vertex.data.vertex_index < vertex.data.fan_length, "vertex index past fan end")
    `BSFT_ASSERT_IMPL(a_len_code, vertex.valid,
        vertex.data.fan_length == SQ_LEN || vertex.data.fan_length == ARC_LEN,
        "bad fan length")

endmodule

// ===== rtl/core/bsft_div.sv =====
module bsft_div (
    input  logic               clk,
    input  logic               rst_n,
    input  bsft_pkg::div_req_t req,
    output bsft_pkg::div_rsp_t rsp
);

    localparam int CNT_W = $clog2(bsft_pkg::DVD_W + 1);

    logic                       busy_reg;
    logic                       done_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [bsft_pkg::DVD_W-1:0] quo_reg;
    logic [bsft_pkg::DVS_W-1:0] rem_reg;
    logic [bsft_pkg::DVS_W-1:0] dvs_reg;
    logic [bsft_pkg::DVS_W:0]   rem_sh;
    logic                       ge;
    logic [bsft_pkg::DVS_W-1:0] rem_next;
    logic [bsft_pkg::DVD_W-1:0] quo_next;

    // one restoring step: shift in a dividend bit, subtract if it fits
    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[bsft_pkg::DVD_W-1]};
        ge       = rem_sh >= {1'b0, dvs_reg};
        rem_next = ge ? bsft_pkg::DVS_W'(rem_sh - {1'b0, dvs_reg})
                      : rem_sh[bsft_pkg::DVS_W-1:0];
        quo_next = {quo_reg[bsft_pkg::DVD_W-2:0], ge};
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(bsft_pkg::DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // partial remainder and quotient
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== rtl/core/bsft_mul.sv =====
module bsft_mul (
    input  logic               clk,
    input  bsft_pkg::mul_req_t req,
    output logic signed [41:0] prod
);

    logic signed [41:0] prod_reg;

    // unsigned by signed product, registered
    always_ff @(posedge clk)
    begin
        prod_reg <= $signed({1'b0, req.a}) * req.b;
    end

    assign prod = prod_reg;

endmodule

// ===== tb/bsft_fan_checker.sv =====
`timescale 1ns / 100ps

module bsft_fan_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    bsft_box_if         box,
    bsft_vtx_if         vertex,
    output int          errors,
    output int          pending
);

    localparam int FAN_STEPS = bsft_pkg::ARC_STEPS_DEF;
    localparam int FRAC      = bsft_pkg::COORD_FRAC_BITS_DEF;
    localparam longint UNIT  = 64'sd1 <<< 32;
    localparam longint RCAP  = 64'sd1 <<< 44;
    localparam longint VCAP  = 64'sd1 <<< 50;

    // sine of the first quarter at 10-degree steps, 1.0 is 65536
    localparam int SIN_Q16 [10] = '{0, 11380, 22415, 32768, 42126,
                                     50203, 56756, 61584, 64540, 65536};

    logic [1:0]  shape;
    logic [15:0] radius;
    logic [13:0] width_px;
    logic [13:0] height_px;
    logic [31:0] vertex_total;
    bsft_pkg::vtx_t expected_vertices [$];

    assign pending = expected_vertices.size();

    // signed sine for k*10 degrees
    function automatic longint sine10(int k);
        int m;
        m = k % 36;
        if (m <= 9)
            return SIN_Q16[m];
        else if (m <= 18)
            return SIN_Q16[18 - m];
        else if (m <= 27)
            return -SIN_Q16[m - 18];
        else
            return -SIN_Q16[36 - m];
    endfunction

    // projection value in 2^-32 units to rounded, saturated output coordinate
    function automatic logic [15:0] to_coord(longint v);
        longint q;
        if (v > VCAP)
            v = VCAP;
        if (v < -VCAP)
            v = -VCAP;
        q = (v + (64'sd1 <<< (31 - FRAC))) >>> (32 - FRAC);
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return q[15:0];
    endfunction

    function automatic longint clamp_radius(longint r);
        return (r > RCAP) ? RCAP : r;
    endfunction

    function automatic longint scale_trig(longint r, longint t);
        return (r * t) >>> 16;
    endfunction

    task automatic queue_vertex(int idx, int len, logic [31:0] first, longint x, longint y);
        bsft_pkg::vtx_t v;
        v.vertex_x     = to_coord(x);
        v.vertex_y     = to_coord(y);
        v.vertex_index = idx[5:0];
        v.fan_start    = first;
        v.fan_length   = len[5:0];
        v.last         = (idx == len - 1);
        expected_vertices = {expected_vertices, v};
    endtask

    // expected vertices of one box under the current settings
    task automatic predict_fan(bsft_pkg::box_t b);
        longint ax0, ay0, ax1, ay1, cx, cy, adx, ady, w, h, rs, rx, ry, x, y, bx, by;
        longint xa, xb, ya, yb, mw, mh, mm;
        int len, k, q;
        logic [31:0] first;
        ax0 = b.min_x;
        ay0 = b.min_y;
        ax1 = b.max_x;
        ay1 = b.max_y;
        w = (width_px == 0) ? 1 : width_px;
        h = (height_px == 0) ? 1 : height_px;
        cx = (ax0 + ax1) * 65536 - UNIT;
        cy = UNIT - (ay0 + ay1) * 65536;
        adx = (ax1 > ax0) ? ax1 - ax0 : ax0 - ax1;
        ady = (ay1 > ay0) ? ay1 - ay0 : ay0 - ay1;
        rs = longint'(radius) * longint'(b.scale);
        if (b.restart)
            vertex_total = '0;
        first = vertex_total;
        x = 0;
        y = 0;
        if (shape == bsft_pkg::MODE_ROUND || shape == bsft_pkg::MODE_CIRCLE)
        begin
            len = FAN_STEPS + 2;
            if (shape == bsft_pkg::MODE_ROUND)
            begin
                rx = clamp_radius((rs <<< 18) / w);
                ry = clamp_radius((rs <<< 18) / h);
                xa = cx + (adx * 65536 - rx);
                xb = cx - (adx * 65536 - rx);
                ya = cy + (ady * 65536 - ry);
                yb = cy - (ady * 65536 - ry);
            end
            else
            begin
                if (radius != 0)
                begin
                    rx = clamp_radius((rs <<< 19) / w);
                    ry = clamp_radius((rs <<< 19) / h);
                end
                else
                begin
                    mw = adx * 131072 * w;
                    mh = ady * 131072 * h;
                    mm = (mw > mh) ? mw : mh;
                    rx = clamp_radius(mm / (2 * w));
                    ry = clamp_radius(mm / (2 * h));
                end
                xa = cx;
                xb = cx;
                ya = cy;
                yb = cy;
            end
            queue_vertex(0, len, first, cx, cy);
            for (int i = 0; i < FAN_STEPS; i++)
            begin
                k = i * 36 / FAN_STEPS;
                q = (i * 4 / FAN_STEPS) & 3;
                bx = (q == 1 || q == 2) ? xb : xa;
                by = (q >= 2) ? yb : ya;
                x = bx + scale_trig(rx, sine10(k + 9));
                y = by + scale_trig(ry, sine10(k));
                queue_vertex(i + 1, len, first, x, y);
            end
            if (shape == bsft_pkg::MODE_ROUND)
                queue_vertex(len - 1, len, first, x, ya);
            else
                queue_vertex(len - 1, len, first, cx + rx, cy);
        end
        else
        begin
            len = bsft_pkg::SQUARE_LEN;
            xa = ax0 * 131072 - UNIT;
            xb = ax1 * 131072 - UNIT;
            ya = UNIT - ay0 * 131072;
            yb = UNIT - ay1 * 131072;
            queue_vertex(0, len, first, xa, ya);
            queue_vertex(1, len, first, xb, ya);
            queue_vertex(2, len, first, xa, yb);
            queue_vertex(3, len, first, xb, ya);
            queue_vertex(4, len, first, xb, yb);
            queue_vertex(5, len, first, xa, yb);
        end
        vertex_total = first + 32'(len);
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0t] vertex mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // track settings, predict on each box request, compare each vertex request
    always @(posedge clk or negedge rst_n)
    begin
        bsft_pkg::vtx_t got;
        bsft_pkg::vtx_t want;
        if (!rst_n)
        begin
            shape        = bsft_pkg::MODE_SQUARE;
            radius       = '0;
            width_px     = 14'd1024;
            height_px    = 14'd1024;
            vertex_total = '0;
            errors       = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    bsft_pkg::CFG_SHAPE_MODE:    shape = cfg_data[1:0];
                    bsft_pkg::CFG_CORNER_RADIUS: radius = cfg_data;
                    bsft_pkg::CFG_CANVAS_WIDTH:  width_px = cfg_data[13:0];
                    bsft_pkg::CFG_CANVAS_HEIGHT: height_px = cfg_data[13:0];
                    default: ;
                endcase
            end
            if (box.valid && box.ready)
                predict_fan(box.data);
            if (vertex.valid && vertex.ready)
            begin
                got = vertex.data;
                if (expected_vertices.size() == 0)
                    report_mismatch("vertex_index with none expected", got.vertex_index, -1);
                else
                begin
                    want = expected_vertices.pop_front();
                    if (got.vertex_x !== want.vertex_x)
                        report_mismatch("vertex_x", got.vertex_x, want.vertex_x);
                    if (got.vertex_y !== want.vertex_y)
                        report_mismatch("vertex_y", got.vertex_y, want.vertex_y);
                    if (got.vertex_index !== want.vertex_index)
                        report_mismatch("vertex_index", got.vertex_index, want.vertex_index);
                    if (got.fan_start !== want.fan_start)
                        report_mismatch("fan_start", got.fan_start, want.fan_start);
                    if (got.fan_length !== want.fan_length)
                        report_mismatch("fan_length", got.fan_length, want.fan_length);
                    if (got.last !== want.last)
                        report_mismatch("last", got.last, want.last);
                end
            end
        end
    end

endmodule

// ===== tb/tb_background_shape_fan_tessellator.sv =====
`timescale 1ns / 100ps

module tb_background_shape_fan_tessellator;

    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 400;
    localparam int LONG_HOLD      = 700;
    localparam int PHASES         = 10;
    localparam int ITEMS_PER_PHASE = 38;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    int          errors;
    int          pending;
    int          idle_cycles;
    bit          quiet;
    int          hold_count;
    int          hold_left;
    int          stall_left;

    bsft_box_if box_ch ();
    bsft_vtx_if vtx_ch ();

    background_shape_fan_tessellator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .box       (box_ch.sink),
        .vertex    (vtx_ch.source)
    );

    bsft_fan_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .box       (box_ch),
        .vertex    (vtx_ch),
        .errors    (errors),
        .pending   (pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog on cycles with no request moving
    always @(posedge clk)
    begin
        if (!rst_n || (box_ch.valid && box_ch.ready) || (vtx_ch.valid && vtx_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_background_shape_fan_tessellator NOT OK");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // vertex receiver with short and long stalls, plus a long hold on each hold request
    initial
    begin
        int r;
        int holds_taken;
        vtx_ch.ready = 1'b0;
        hold_left = 0;
        stall_left = 0;
        holds_taken = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_count != holds_taken)
            begin
                holds_taken = hold_count;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                vtx_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                vtx_ch.ready <= 1'b0;
            end
            else if (quiet)
                vtx_ch.ready <= 1'b1;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 75)
                    vtx_ch.ready <= 1'b1;
                else
                begin
                    stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(15, 60);
                    vtx_ch.ready <= 1'b0;
                end
            end
        end
    end

    task automatic send_box(bsft_pkg::box_t b);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 70)
            gap = 0;
        else if (r < 94)
            gap = $urandom_range(1, 4);
        else
            gap = $urandom_range(10, 60);
        if (gap > 0)
        begin
            @(negedge clk);
            box_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        box_ch.valid <= 1'b1;
        box_ch.data  <= b;
        do
            @(posedge clk);
        while (!box_ch.ready);
    endtask

    function automatic bsft_pkg::box_t random_box();
        bsft_pkg::box_t b;
        logic [15:0] a;
        logic [15:0] c;
        int r;
        r = $urandom_range(0, 99);
        a = 16'($urandom_range(0, 65535));
        c = 16'($urandom_range(0, 65535));
        // mostly ordered boxes, some inverted, some at the edges
        if (r < 75)
        begin
            b.min_x = (a < c) ? a : c;
            b.max_x = (a < c) ? c : a;
        end
        else
        begin
            b.min_x = (r < 90) ? ((a < c) ? c : a) : 16'h0000;
            b.max_x = (r < 90) ? ((a < c) ? a : c) : 16'hFFFF;
        end
        a = 16'($urandom_range(0, 65535));
        c = 16'($urandom_range(0, 65535));
        b.min_y = (r < 75) ? ((a < c) ? a : c) : a;
        b.max_y = (r < 75) ? ((a < c) ? c : a) : c;
        r = $urandom_range(0, 9);
        if (r < 5)
            b.scale = 16'($urandom_range(64, 1024));
        else if (r < 9)
            b.scale = 16'($urandom_range(0, 65535));
        else
            b.scale = (r[0]) ? 16'hFFFF : 16'h0000;
        b.restart = ($urandom_range(0, 7) == 0);
        return b;
    endfunction

    function automatic bsft_pkg::box_t make_box(logic [15:0] x0, logic [15:0] y0,
                                                logic [15:0] x1, logic [15:0] y1,
                                                logic [15:0] s, logic rs);
        bsft_pkg::box_t b;
        b.min_x = x0;
        b.min_y = y0;
        b.max_x = x1;
        b.max_y = y1;
        b.scale = s;
        b.restart = rs;
        return b;
    endfunction

    task automatic write_reg(bsft_pkg::cfg_index_t idx, logic [15:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
    endtask

    // all four registers, then release the write enable
    task automatic set_shape(logic [1:0] m, logic [15:0] rad, logic [15:0] w, logic [15:0] h);
        write_reg(bsft_pkg::CFG_SHAPE_MODE, {14'd0, m});
        write_reg(bsft_pkg::CFG_CORNER_RADIUS, rad);
        write_reg(bsft_pkg::CFG_CANVAS_WIDTH, w);
        write_reg(bsft_pkg::CFG_CANVAS_HEIGHT, h);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // stimulus and verdict
    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = bsft_pkg::CFG_SHAPE_MODE;
        cfg_data     = '0;
        box_ch.valid = 1'b0;
        box_ch.data  = '0;
        quiet        = 1'b0;
        hold_count   = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                @(negedge clk);
                box_ch.valid <= 1'b0;
                wait_idle();
            end
            case (p)
                0: ;
                1: set_shape(bsft_pkg::MODE_ROUND, 16'd512, 16'd1024, 16'd768);
                2: set_shape(bsft_pkg::MODE_CIRCLE, 16'd0, 16'd1920, 16'd1080);
                3: set_shape(bsft_pkg::MODE_CIRCLE, 16'd1000, 16'd8192, 16'd1);
                4: set_shape(MODE_SPARE, 16'd5, 16'd0, 16'd0);
                5: set_shape(bsft_pkg::MODE_ROUND, 16'hFFFF, 16'd1, 16'd1);
                6: set_shape(bsft_pkg::MODE_ROUND, 16'd0, 16'd8192, 16'd8192);
                7: set_shape(bsft_pkg::MODE_CIRCLE, 16'($urandom_range(0, 65535)),
                             16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
                8: set_shape(bsft_pkg::MODE_SQUARE, 16'($urandom_range(0, 65535)),
                             16'd640, 16'd480);
                default: set_shape(bsft_pkg::MODE_ROUND, 16'($urandom_range(0, 2048)),
                                   16'($urandom_range(1, 8192)), 16'($urandom_range(1, 8192)));
            endcase
            quiet = (p % 3 == 2);

            // directed corners of the fields
            if (p < 3 || p == 5)
            begin
                send_box(make_box(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0100, 1'b1));
                send_box(make_box(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 1'b0));
                send_box(make_box(16'h4000, 16'h4000, 16'h4000, 16'h4000, 16'h0000, 1'b0));
                send_box(make_box(16'h1000, 16'h2000, 16'hC000, 16'h9000, 16'h0200, 1'b0));
                send_box(make_box(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0001, 1'b1));
            end

            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                send_box(random_box());
                // fill the block up while the receiver sits out a long stretch
                if ((p == 1 || p == 8) && i == 3)
                    hold_count = hold_count + 1;
            end
        end
        @(negedge clk);
        box_ch.valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("tb_background_shape_fan_tessellator OK");
        else
            $display("tb_background_shape_fan_tessellator NOT OK");
        $finish;
    end

endmodule
